FILE: hw/rtl/c16k_pkg.sv
// ----------------------------------------------------------------------------
// c16k_pkg
// Shared types and codeword constants for the Code 16K text decoder.
// ----------------------------------------------------------------------------
package c16k_pkg;

  typedef enum logic [1:0] {
    SET_A = 2'd0,
    SET_B = 2'd1,
    SET_C = 2'd2
  } code_set_e;

  localparam logic [6:0] CW_SHIFT  = 7'd98;
  localparam logic [6:0] CW_CODE_C = 7'd99;
  localparam logic [6:0] CW_CODE_B = 7'd100;
  localparam logic [6:0] CW_CODE_A = 7'd101;
  localparam logic [6:0] CW_PAD    = 7'd106;
  localparam logic [6:0] CW_DIGITS = 7'd100;  // set C pairs lie below this
  localparam logic [6:0] CW_ALPHA  = 7'd64;   // set A control chars start here
  localparam logic [6:0] CW_CHARS  = 7'd96;   // set A/B characters lie below this
  localparam logic [7:0] CHAR_BASE = 8'd32;
  localparam logic [7:0] HIGH_BIT  = 8'd128;
  localparam logic [7:0] DIGIT_0   = 8'h30;

  typedef struct packed {
    code_set_e code_set;
    logic      high_bit;
    logic      shift;
  } c16k_state_t;

  typedef struct packed {
    logic [1:0] count;  // 0, 1 or 2 bytes
    logic [7:0] char0;  // first byte when count is two
    logic [7:0] char1;  // only or second byte
  } c16k_result_t;

endpackage

FILE: hw/rtl/c16k_if.sv
// ----------------------------------------------------------------------------
// c16k_in_if / c16k_out_if
// Valid/ready channels for codeword requests and decoded text bytes.
// ----------------------------------------------------------------------------
interface c16k_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] codeword;
  logic       first_of_symbol;
  logic [2:0] mode;

  modport source (output valid, codeword, first_of_symbol, mode, input ready);
  modport sink   (input valid, codeword, first_of_symbol, mode, output ready);
endinterface

interface c16k_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

FILE: hw/rtl/c16k_decode.sv
// ----------------------------------------------------------------------------
// c16k_decode
// Code set interpretation of one codeword: result bytes and next state.
// ----------------------------------------------------------------------------
module c16k_decode
  import c16k_pkg::*;
(
  input  c16k_state_t  state_i,
  input  logic [6:0]   codeword_i,
  input  logic         first_i,
  input  logic [2:0]   mode_i,
  output c16k_state_t  state_o,
  output c16k_result_t result_o
);

  c16k_state_t  st;
  code_set_e    eff;
  logic [17:0]  prod;
  logic [3:0]   tens;
  logic [6:0]   ones;
  logic [7:0]   chr;
  logic [7:0]   hb;

  // state after an optional symbol restart
  always_comb begin
    st = state_i;
    if (first_i) begin
      st.high_bit = 1'b0;
      st.shift    = 1'b0;
      case (mode_i)
        3'd1, 3'd5:       st.code_set = SET_B;
        3'd2, 3'd4, 3'd6: st.code_set = SET_C;
        default:          st.code_set = SET_A;
      endcase
    end
  end

  // divide by ten through reciprocal, exact for codewords below 128
  assign prod = 18'(codeword_i) * 18'd205;
  assign tens = prod[14:11];
  assign ones = codeword_i - (7'(tens) * 7'd10);
  assign hb   = st.high_bit ? HIGH_BIT : 8'd0;

  always_comb begin
    if (st.shift) begin
      eff = (st.code_set == SET_A) ? SET_B : SET_A;
    end else if (st.code_set == SET_C) begin
      eff = SET_C;
    end else if (st.code_set == SET_A) begin
      eff = SET_A;
    end else begin
      eff = SET_B;
    end
  end

  always_comb begin
    state_o        = st;
    state_o.shift  = 1'b0;
    result_o.count = 2'd0;
    result_o.char0 = 8'(DIGIT_0 + 8'(tens));
    result_o.char1 = 8'd0;
    chr            = 8'(codeword_i) + CHAR_BASE;
    if (codeword_i == CW_PAD) begin
      state_o = st;  // padding keeps a pending shift
    end else begin
      case (eff)
        SET_C: begin
          if (codeword_i < CW_DIGITS) begin
            result_o.count = 2'd2;
            result_o.char1 = 8'(DIGIT_0 + 8'(ones));
          end else if (codeword_i == CW_CODE_A) begin
            state_o.code_set = SET_A;
          end else if (codeword_i == CW_CODE_B) begin
            state_o.code_set = SET_B;
          end
        end
        SET_A: begin
          if (codeword_i < CW_CHARS) begin
            if (codeword_i >= CW_ALPHA) begin
              chr = 8'(codeword_i - CW_ALPHA);
            end
            result_o.count = 2'd1;
            result_o.char1 = chr + hb;
          end else if (codeword_i == CW_SHIFT) begin
            state_o.shift = 1'b1;
          end else if (codeword_i == CW_CODE_B) begin
            state_o.code_set = SET_B;
          end else if (codeword_i == CW_CODE_C) begin
            state_o.code_set = SET_C;
          end else if (codeword_i == CW_CODE_A) begin
            state_o.high_bit = ~st.high_bit;
          end
        end
        default: begin
          if (codeword_i < CW_CHARS) begin
            result_o.count = 2'd1;
            result_o.char1 = chr + hb;
          end else if (codeword_i == CW_SHIFT) begin
            state_o.shift = 1'b1;
          end else if (codeword_i == CW_CODE_A) begin
            state_o.code_set = SET_A;
          end else if (codeword_i == CW_CODE_C) begin
            state_o.code_set = SET_C;
          end else if (codeword_i == CW_CODE_B) begin
            state_o.high_bit = ~st.high_bit;
          end
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/code16k_codeword_to_text_core.sv
// ----------------------------------------------------------------------------
// code16k_codeword_to_text_core
// Code 16K data codewords in, decoded text bytes out.
// ----------------------------------------------------------------------------
// A request is latched in an input register, decoded against the code set
// state and moved into a two-byte result buffer. Codewords that give one
// byte or none sustain one request per cycle while the output takes bytes;
// a set C digit pair gives two bytes on the single output channel, so a
// later request that gives bytes waits in the input register until the
// pair's second byte is taken. The last flag marks a codeword's final byte.
module code16k_codeword_to_text_core
  import c16k_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  c16k_in_if.sink    in_i,
  c16k_out_if.source out_o
);

  logic         in_valid_q;
  logic [6:0]   codeword_q;
  logic         first_q;
  logic [2:0]   mode_q;
  c16k_state_t  state_q, state_d;
  c16k_result_t res;
  logic [1:0]   cnt_q, cnt_d;
  logic [7:0]   char0_q, char1_q;
  logic         out_fire;
  logic         advance;

  c16k_decode u_decode (
    .state_i    (state_q),
    .codeword_i (codeword_q),
    .first_i    (first_q),
    .mode_i     (mode_q),
    .state_o    (state_d),
    .result_o   (res)
  );

  assign out_fire = out_o.valid && out_o.ready;
  // decoded request moves on once the buffer has room for its bytes
  assign advance  = in_valid_q && ((res.count == 2'd0) || (cnt_q == 2'd0) ||
                    ((cnt_q == 2'd1) && out_fire));
  assign in_i.ready = !in_valid_q || advance;

  always_comb begin
    cnt_d = cnt_q;
    if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
    if (advance && (res.count != 2'd0)) begin
      cnt_d = res.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      cnt_q            <= 2'd0;
      state_q.code_set <= SET_A;
      state_q.high_bit <= 1'b0;
      state_q.shift    <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      codeword_q <= in_i.codeword;
      first_q    <= in_i.first_of_symbol;
      mode_q     <= in_i.mode;
    end
    if (advance && (res.count != 2'd0)) begin
      char0_q <= res.char0;
      char1_q <= res.char1;
    end
  end

  assign out_o.valid    = cnt_q != 2'd0;
  assign out_o.out_char = (cnt_q == 2'd2) ? char0_q : char1_q;
  assign out_o.last     = cnt_q == 2'd1;

endmodule
